/* rtl/gso_pkg.sv */
// ----------------------------------------------------------------------------
// gso_pkg
// Shared types and constants of the Gram-Schmidt orthonormalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package gso_pkg;

    // element word and register widths
    localparam int DATA_W     = 32;
    localparam int VLEN_W     = 5;
    localparam int VCNT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // default geometry
    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_COLS  = 4;
    localparam int DEF_FRAC_BITS = 16;

    // register reset values
    localparam logic [VLEN_W-1:0] VLEN_RESET = 5'd16;
    localparam logic [VCNT_W-1:0] VCNT_RESET = 3'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_VECTOR_COUNT  = 1'b1
    } cfg_index_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_COEF,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WB,
        ST_SQ_RD,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_NRM_RD,
        ST_NRM_PREP,
        ST_NRM_DIV,
        ST_NRM_WB,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

`default_nettype wire

/* rtl/gso_if.sv */
// ----------------------------------------------------------------------------
// gso_if
// Valid/ready channels of the orthonormalizer: sample in, result out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface gso_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [gso_pkg::DATA_W-1:0] element_in;

    modport source (output valid, output element_in, input ready);
    modport sink   (input valid, input element_in, output ready);
endinterface

interface gso_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gso_pkg::DATA_W-1:0] element_out;
    logic                              column_degenerate;
    logic                              last_out;

    modport source (output valid, output element_out, output column_degenerate,
                    output last_out, input ready);
    modport sink   (input valid, input element_out, input column_degenerate,
                    input last_out, output ready);
endinterface

interface gso_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [gso_pkg::CFG_IDX_W-1:0]       index;
    logic [gso_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/gram_schmidt_orthonormalizer.sv */
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalizer
// Loads a matrix column-major into a store, orthonormalizes it in place with
// modified Gram-Schmidt and streams the result out column-major.
// ----------------------------------------------------------------------------
// Loading takes one element per cycle while no config write is offered. After
// the last element, each column is projected against the earlier ones, its norm
// found by the one-bit-per-cycle square root and, if the column is not degenerate,
// divided into its elements by the restoring divider (one quotient bit per cycle).
// Output then streams the elements, one store read each.
// Reset clears the sequencer, counters and config; store and datapath are not.
`default_nettype none

module gram_schmidt_orthonormalizer #(
    parameter int MAX_ROWS  = gso_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gso_pkg::DEF_MAX_COLS,
    parameter int FRAC_BITS = gso_pkg::DEF_FRAC_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gso_in_if.sink     sample,
    gso_out_if.source  result,
    gso_cfg_if.sink    cfg
);
    import gso_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = $clog2(DEPTH + 1);
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NUM_W  = DATA_W + FRAC_BITS + 1;
    localparam int DIT_W  = $clog2(NUM_W);
    localparam int SIT_W  = 5;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic [63:0]        HALF    = 64'(1) << (FRAC_BITS - 1);

    // arithmetic helpers
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] round_q(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? (64'd0 - x) : x;
        m = (m + HALF) >> FRAC_BITS;
        return x[63] ? (64'd0 - m) : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // registers
    state_t                    state_reg, state_next;
    logic [VLEN_W-1:0]         vlen_reg, vlen_next;
    logic [VCNT_W-1:0]         vcnt_reg, vcnt_next;
    logic [TW-1:0]             load_reg, load_next;
    logic [RW-1:0]             r_reg, r_next;
    logic [CW-1:0]             c_reg, c_next;
    logic [CW-1:0]             p_reg, p_next;
    logic [TW-1:0]             base_reg, base_next;
    logic [TW-1:0]             pb_reg, pb_next;
    logic [TW-1:0]             k_reg, k_next;
    logic [RW-1:0]             erow_reg, erow_next;
    logic [CW-1:0]             ecol_reg, ecol_next;
    logic                      degen_reg [MAX_COLS];
    logic                      degen_we;
    logic [SIT_W-1:0]          sit_reg, sit_next;
    logic [DIT_W-1:0]          dit_reg, dit_next;
    logic signed [63:0]        acc_reg, acc_next;
    logic signed [63:0]        prod_reg;
    logic signed [31:0]        coef_reg, coef_next;
    logic [33:0]               srem_reg, srem_next;
    logic [31:0]               sroot_reg, sroot_next;
    logic [31:0]               norm_reg, norm_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [31:0]               drem_reg, drem_next;
    logic signed [DATA_W-1:0]  rd_a_reg, rd_b_reg;

    // store
    logic signed [DATA_W-1:0]  store_mem [DEPTH];
    logic                      we, re_a, re_b;
    logic [AW-1:0]             wa, ra, rb;
    logic signed [DATA_W-1:0]  wd;

    // geometry in use
    logic [RW-1:0] rows_use;
    logic [CW-1:0] cols_use;
    logic [TW-1:0] total;
    logic [TW-1:0] load_idx;
    logic [TW-1:0] addr_a, addr_b;

    always_comb
    begin
        if (vlen_reg == '0)
            rows_use = RW'(1);
        else if (32'(vlen_reg) > 32'(MAX_ROWS))
            rows_use = RW'(MAX_ROWS);
        else
            rows_use = RW'(32'(vlen_reg));
        if (vcnt_reg == '0)
            cols_use = CW'(1);
        else if (32'(vcnt_reg) > 32'(MAX_COLS))
            cols_use = CW'(MAX_COLS);
        else
            cols_use = CW'(32'(vcnt_reg));
        total    = TW'(32'(rows_use) * 32'(cols_use));
        load_idx = (load_reg >= total) ? '0 : load_reg;
        addr_a   = base_reg + TW'(r_reg);
        addr_b   = pb_reg + TW'(r_reg);
    end

    logic sample_fire, result_fire, cfg_fire;
    logic row_last, col_last, emit_last;

    assign sample_fire = sample.valid && sample.ready;
    assign result_fire = result.valid && result.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign row_last    = (r_reg + RW'(1)) == rows_use;
    assign col_last    = (c_reg + CW'(1)) == cols_use;
    assign emit_last   = (k_reg + TW'(1)) == total;

    // datapath values
    logic signed [63:0] mul_a, mul_b;
    logic signed [63:0] upd_v;
    logic signed [31:0] upd_word;
    logic [64:0]        sq_sum;
    logic [34:0]        srem_s, strial;
    logic [32:0]        drem_s;
    logic [31:0]        mag32;
    logic signed [31:0] nrm_word;

    always_comb
    begin
        upd_v    = 64'(rd_a_reg) - round_q(prod_reg);
        upd_word = sat32(upd_v);
        sq_sum   = {1'b0, acc_reg} + {1'b0, prod_reg};
        srem_s   = {srem_reg[32:0], acc_reg[63:62]};
        strial   = {1'b0, sroot_reg, 2'b01};
        drem_s   = {drem_reg, num_reg[NUM_W-1]};
        mag32    = rd_a_reg[31] ? (32'd0 - rd_a_reg) : rd_a_reg;
        if (rd_a_reg[31])
            nrm_word = (num_reg > NUM_W'(32'h80000000)) ? 32'sh80000000
                                                         : (32'd0 - num_reg[31:0]);
        else
            nrm_word = (num_reg > NUM_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                         : num_reg[31:0];
    end

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_UPD_MUL:
            begin
                mul_a = 64'(coef_reg);
                mul_b = 64'(rd_b_reg);
            end
            ST_SQ_MUL:
            begin
                mul_a = 64'(rd_a_reg);
                mul_b = 64'(rd_a_reg);
            end
            default:
            begin
                mul_a = 64'(rd_a_reg);
                mul_b = 64'(rd_b_reg);
            end
        endcase
    end

    // next state and datapath
    always_comb
    begin
        logic begin_col;
        logic end_col;
        begin_col  = 1'b0;
        end_col    = 1'b0;
        state_next = state_reg;
        vlen_next  = vlen_reg;
        vcnt_next  = vcnt_reg;
        load_next  = load_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        base_next  = base_reg;
        pb_next    = pb_reg;
        k_next     = k_reg;
        erow_next  = erow_reg;
        ecol_next  = ecol_reg;
        sit_next   = sit_reg;
        dit_next   = dit_reg;
        acc_next   = acc_reg;
        coef_next  = coef_reg;
        srem_next  = srem_reg;
        sroot_next = sroot_reg;
        norm_next  = norm_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        degen_we   = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (sample_fire)
                begin
                    if ((load_idx + TW'(1)) == total)
                    begin
                        load_next = '0;
                        c_next    = '0;
                        base_next = '0;
                        begin_col = 1'b1;
                    end
                    else
                        load_next = load_idx + TW'(1);
                end
            end
            ST_DOT_RD:   state_next = ST_DOT_MUL;
            ST_DOT_MUL:  state_next = ST_DOT_ACC;
            ST_DOT_ACC:
            begin
                acc_next = sat_add64(acc_reg, prod_reg);
                if (row_last)
                begin
                    r_next     = '0;
                    state_next = ST_COEF;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_DOT_RD;
                end
            end
            ST_COEF:
            begin
                coef_next  = sat32(round_q(acc_reg));
                state_next = ST_UPD_RD;
            end
            ST_UPD_RD:   state_next = ST_UPD_MUL;
            ST_UPD_MUL:  state_next = ST_UPD_WB;
            ST_UPD_WB:
            begin
                if (row_last)
                begin
                    r_next   = '0;
                    p_next   = p_reg + CW'(1);
                    pb_next  = pb_reg + TW'(rows_use);
                    acc_next = '0;
                    state_next = ((p_reg + CW'(1)) == c_reg) ? ST_SQ_RD : ST_DOT_RD;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_UPD_RD;
                end
            end
            ST_SQ_RD:    state_next = ST_SQ_MUL;
            ST_SQ_MUL:   state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                acc_next = sq_sum[64] ? '1 : sq_sum[63:0];
                if (row_last)
                begin
                    r_next     = '0;
                    srem_next  = '0;
                    sroot_next = '0;
                    sit_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_SQ_RD;
                end
            end
            ST_SQRT:
            begin
                // one root bit per cycle, radicand shifts out of acc
                acc_next = acc_reg << 2;
                if (srem_s >= strial)
                begin
                    srem_next  = 34'(srem_s - strial);
                    sroot_next = {sroot_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_next  = 34'(srem_s);
                    sroot_next = {sroot_reg[30:0], 1'b0};
                end
                sit_next = sit_reg + SIT_W'(1);
                if (sit_reg == '1)
                begin
                    norm_next = sroot_next;
                    degen_we  = 1'b1;
                    if (sroot_next == '0)
                        end_col = 1'b1;
                    else
                        state_next = ST_NRM_RD;
                end
            end
            ST_NRM_RD:   state_next = ST_NRM_PREP;
            ST_NRM_PREP:
            begin
                num_next   = (NUM_W'(mag32) << FRAC_BITS) + NUM_W'(norm_reg >> 1);
                drem_next  = '0;
                dit_next   = '0;
                state_next = ST_NRM_DIV;
            end
            ST_NRM_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (drem_s >= {1'b0, norm_reg})
                begin
                    drem_next = 32'(drem_s - {1'b0, norm_reg});
                    num_next  = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_s[31:0];
                    num_next  = {num_reg[NUM_W-2:0], 1'b0};
                end
                dit_next = dit_reg + DIT_W'(1);
                if (dit_reg == DIT_W'(NUM_W - 1))
                    state_next = ST_NRM_WB;
            end
            ST_NRM_WB:
            begin
                if (row_last)
                begin
                    r_next  = '0;
                    end_col = 1'b1;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_NRM_RD;
                end
            end
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (result_fire)
                begin
                    if (emit_last)
                        state_next = ST_LOAD;
                    else
                    begin
                        k_next = k_reg + TW'(1);
                        if ((erow_reg + RW'(1)) == rows_use)
                        begin
                            erow_next = '0;
                            ecol_next = ecol_reg + CW'(1);
                        end
                        else
                            erow_next = erow_reg + RW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:     state_next = ST_LOAD;
        endcase

        // column finished: next column or start output
        if (end_col)
        begin
            if (col_last)
            begin
                k_next     = '0;
                erow_next  = '0;
                ecol_next  = '0;
                state_next = ST_EMIT_RD;
            end
            else
            begin
                c_next    = c_reg + CW'(1);
                base_next = base_reg + TW'(rows_use);
                begin_col = 1'b1;
            end
        end

        // new column: projections first, if any earlier column exists
        if (begin_col)
        begin
            r_next     = '0;
            p_next     = '0;
            pb_next    = '0;
            acc_next   = '0;
            state_next = (c_next == '0) ? ST_SQ_RD : ST_DOT_RD;
        end

        // register write restarts loading
        if (cfg_fire)
        begin
            load_next = '0;
            unique case (cfg.index)
                CFG_VECTOR_LENGTH: vlen_next = cfg.data[VLEN_W-1:0];
                CFG_VECTOR_COUNT:  vcnt_next = cfg.data[VCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // outputs and store control
    always_comb
    begin
        // config only while loading, and it wins over a sample in the same cycle
        sample.ready              = (state_reg == ST_LOAD) && !cfg.valid;
        cfg.ready                 = (state_reg == ST_LOAD);
        result.valid              = (state_reg == ST_EMIT_OUT);
        result.element_out        = rd_a_reg;
        result.column_degenerate  = degen_reg[ecol_reg[CIW-1:0]];
        result.last_out           = emit_last;

        we   = 1'b0;
        wa   = addr_a[AW-1:0];
        wd   = upd_word;
        re_a = 1'b0;
        re_b = 1'b0;
        ra   = addr_a[AW-1:0];
        rb   = addr_b[AW-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                we = sample_fire;
                wa = load_idx[AW-1:0];
                wd = sample.element_in;
            end
            ST_DOT_RD, ST_UPD_RD:
            begin
                re_a = 1'b1;
                re_b = 1'b1;
            end
            ST_SQ_RD, ST_NRM_RD:
                re_a = 1'b1;
            ST_UPD_WB:
                we = 1'b1;
            ST_NRM_WB:
            begin
                we = 1'b1;
                wd = nrm_word;
            end
            ST_EMIT_RD:
            begin
                re_a = 1'b1;
                ra   = k_reg[AW-1:0];
            end
            default:
                ;
        endcase
    end

    // store write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
            store_mem[wa] <= wd;
        if (re_a)
            rd_a_reg <= store_mem[ra];
        if (re_b)
            rd_b_reg <= store_mem[rb];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            vlen_reg  <= VLEN_RESET;
            vcnt_reg  <= VCNT_RESET;
            load_reg  <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            p_reg     <= '0;
            base_reg  <= '0;
            pb_reg    <= '0;
            k_reg     <= '0;
            erow_reg  <= '0;
            ecol_reg  <= '0;
            sit_reg   <= '0;
            dit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vlen_reg  <= vlen_next;
            vcnt_reg  <= vcnt_next;
            load_reg  <= load_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            p_reg     <= p_next;
            base_reg  <= base_next;
            pb_reg    <= pb_next;
            k_reg     <= k_next;
            erow_reg  <= erow_next;
            ecol_reg  <= ecol_next;
            sit_reg   <= sit_next;
            dit_reg   <= dit_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        prod_reg  <= mul_a * mul_b;
        coef_reg  <= coef_next;
        srem_reg  <= srem_next;
        sroot_reg <= sroot_next;
        norm_reg  <= norm_next;
        num_reg   <= num_next;
        drem_reg  <= drem_next;
        if (degen_we)
            degen_reg[c_reg[CIW-1:0]] <= (sroot_next == '0);
    end

endmodule

`default_nettype wire
